@@ design/rpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle path controller package
// Shared widths, codes, command and status types, and the arctangent table.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int POS_W      = 32;
	localparam int ANG_W      = 16;
	localparam int VEL_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int SPD_W      = 15;
	localparam int TOL_W      = 31;
	localparam int LAP_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = 5;
	localparam int OP_W       = 5;
	localparam int CX_W       = 34;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam logic signed [CX_W-1:0] CORDIC_K = 34'sd652032874;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LAP_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 3'd6;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_DRIVE = 2'd1;
	localparam logic [1:0] MODE_DWELL = 2'd2;
	localparam logic [1:0] MODE_DONE  = 2'd3;

	localparam logic [1:0] EDGE_PX = 2'd0;
	localparam logic [1:0] EDGE_PY = 2'd1;
	localparam logic [1:0] EDGE_NX = 2'd2;
	localparam logic [1:0] EDGE_NY = 2'd3;

	localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
	localparam logic [OP_W-1:0] OP_LATCH   = 5'd1;
	localparam logic [OP_W-1:0] OP_CINIT   = 5'd2;
	localparam logic [OP_W-1:0] OP_CSTEP   = 5'd3;
	localparam logic [OP_W-1:0] OP_CFIN    = 5'd4;
	localparam logic [OP_W-1:0] OP_DIFF    = 5'd5;
	localparam logic [OP_W-1:0] OP_MUL_CDX = 5'd6;
	localparam logic [OP_W-1:0] OP_MUL_SDY = 5'd7;
	localparam logic [OP_W-1:0] OP_MUL_SDX = 5'd8;
	localparam logic [OP_W-1:0] OP_MUL_CDY = 5'd9;
	localparam logic [OP_W-1:0] OP_BY      = 5'd10;
	localparam logic [OP_W-1:0] OP_ERR     = 5'd11;
	localparam logic [OP_W-1:0] OP_MUL_EX2 = 5'd12;
	localparam logic [OP_W-1:0] OP_MUL_EY2 = 5'd13;
	localparam logic [OP_W-1:0] OP_MUL_TOL = 5'd14;
	localparam logic [OP_W-1:0] OP_SINIT   = 5'd15;
	localparam logic [OP_W-1:0] OP_SSTEP   = 5'd16;
	localparam logic [OP_W-1:0] OP_MUL_GE  = 5'd17;
	localparam logic [OP_W-1:0] OP_CLAMP   = 5'd18;
	localparam logic [OP_W-1:0] OP_MUL_V   = 5'd19;
	localparam logic [OP_W-1:0] OP_VSET    = 5'd20;
	localparam logic [OP_W-1:0] OP_DSTEP   = 5'd21;
	localparam logic [OP_W-1:0] OP_DFIN    = 5'd22;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            lane;
		logic [1:0]      edge_idx;
		logic            load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic c_last;
		logic s_last;
		logic d_last;
		logic near;
		logic clamp;
	} dp_stat_t;

	typedef struct packed {
		logic [1:0]       edge_idx;
		logic [LAP_W-1:0] laps;
		logic             fin;
	} adv_t;

	function automatic adv_t adv_edge(input logic [1:0] e, input logic [LAP_W-1:0] l,
		input logic [LAP_W-1:0] lim);
		adv_t r;
		r.edge_idx = e + 2'd1;
		r.laps = l;
		if (r.edge_idx == EDGE_PX && l != {LAP_W{1'b1}}) begin
			r.laps = l + 16'd1;
		end
		r.fin = (r.edge_idx == EDGE_PX) && (r.laps >= lim);
		return r;
	endfunction

	function automatic logic signed [CX_W-1:0] atan_at(input logic [CNT_W-1:0] i);
		logic signed [CX_W-1:0] v;
		case (i)
			5'd0: v = 34'sd536870912;
			5'd1: v = 34'sd316933406;
			5'd2: v = 34'sd167458907;
			5'd3: v = 34'sd85004756;
			5'd4: v = 34'sd42667331;
			5'd5: v = 34'sd21354465;
			5'd6: v = 34'sd10679838;
			5'd7: v = 34'sd5340245;
			5'd8: v = 34'sd2670163;
			5'd9: v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ design/rectangle_path_position_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle path position controller
// Proportional position control along a rectangle with a speed-norm limit.
// ----------------------------------------------------------------------------
// Channel  Handshake                  Payload
// in       in_valid / in_stall        start_req, pos_x, pos_y, heading
// out      out_valid / out_stall      vel_x, vel_y, phase, edge_res, lap, edge_done
// cfg      cfg_we                     cfg_idx, cfg_data
//
// Idle, dwell and done ticks go from accept straight to the output state.
// A driving tick ends early when it reaches tolerance, runs the CORDIC first
// on the first tick of an edge and runs the divider when the speed limit
// applies; the 32-step square root and the 16-step divider dominate. One tick is
// in flight at a time; a new transfer is taken while the previous result waits.
// Reset returns the block to idle.
// ----------------------------------------------------------------------------
module rectangle_path_position_controller #(
	parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rpc_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  wire logic [rpc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 start_req,
	input  wire logic signed [rpc_pkg::POS_W-1:0]     pos_x,
	input  wire logic signed [rpc_pkg::POS_W-1:0]     pos_y,
	input  wire logic [rpc_pkg::ANG_W-1:0]            heading,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [rpc_pkg::VEL_W-1:0]          vel_x,
	output logic signed [rpc_pkg::VEL_W-1:0]          vel_y,
	output logic [1:0]                                phase,
	output logic [1:0]                                edge_res,
	output logic [rpc_pkg::LAP_W-1:0]                 lap,
	output logic                                      edge_done
);

	rpc_pkg::dp_cmd_t  cmd;
	rpc_pkg::dp_stat_t stat;

	rpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.phase     (phase),
		.edge_res  (edge_res),
		.lap       (lap),
		.edge_done (edge_done),
		.cmd       (cmd),
		.stat      (stat)
	);

	rpc_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.heading  (heading),
		.cmd      (cmd),
		.stat     (stat),
		.vel_x    (vel_x),
		.vel_y    (vel_y)
	);

endmodule
`default_nettype wire

@@ design/rpc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle path controller datapath
// CORDIC, shared multiplier, square root and divider steps under command.
// ----------------------------------------------------------------------------
module rpc_datapath #(
	parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rpc_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  wire logic [rpc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic signed [rpc_pkg::POS_W-1:0]     pos_x,
	input  wire logic signed [rpc_pkg::POS_W-1:0]     pos_y,
	input  wire logic [rpc_pkg::ANG_W-1:0]            heading,
	input  wire rpc_pkg::dp_cmd_t                     cmd,
	output rpc_pkg::dp_stat_t                         stat,
	output logic signed [rpc_pkg::VEL_W-1:0]          vel_x,
	output logic signed [rpc_pkg::VEL_W-1:0]          vel_y
);

	localparam logic [rpc_pkg::CNT_W-1:0] C_LAST = rpc_pkg::CNT_W'(CORDIC_STEPS - 1);

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh007FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sh0080000000) begin
			r = -32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [16:0] rnd_clamp(input logic signed [33:0] v);
		logic signed [33:0] t;
		logic signed [17:0] s;
		logic signed [16:0] r;
		t = v + 34'sd32768;
		s = t[33:16];
		if (s > 18'sd16384) begin
			r = 17'sd16384;
		end else if (s < -18'sd16384) begin
			r = -17'sd16384;
		end else begin
			r = s[16:0];
		end
		return r;
	endfunction

	logic [rpc_pkg::GAIN_W-1:0] gain_q;
	logic [rpc_pkg::SPD_W-1:0]  ms_q;
	logic [rpc_pkg::TOL_W-1:0]  tol_q;
	logic signed [31:0]         side_x_q, side_y_q;

	logic signed [31:0] px_q, py_q, org_x_q, org_y_q, ex_q, ey_q;
	logic [15:0]        hd_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q, clamp_q;
	logic [rpc_pkg::CNT_W-1:0] cnt_q;
	logic signed [16:0] cos_q, sin_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [65:0] p_q, acc_q;
	logic signed [37:0] bx_q, by_q;
	logic [63:0]        sn_q, sr_q, sb_q;
	logic [47:0]        rem_q;
	logic [15:0]        quo_q;
	logic signed [15:0] vx_q, vy_q, velx_q, vely_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod, rsum;
	logic signed [31:0] e_sel;
	logic [31:0]        e_abs, e_norm;
	logic               e_neg;
	logic signed [39:0] tx, ty;
	logic [15:0]        a_neg;
	logic [31:0]        a_ang;
	logic [63:0]        s_try;
	logic [3:0]         d_sh;
	logic [47:0]        d_div;
	logic signed [33:0] c_xs, c_ys, c_at;
	logic [15:0]        v_trunc, v_mag;
	logic signed [15:0] v_out;

	assign e_norm = sr_q[31:0];
	assign e_sel  = cmd.lane ? ey_q : ex_q;
	assign e_neg  = e_sel[31];
	assign e_abs  = e_neg ? 32'(-e_sel) : e_sel;
	assign a_neg  = 16'(16'd0 - hd_q);
	assign a_ang  = {a_neg ^ {(a_neg[15] ^ a_neg[14]), 15'd0}, 16'd0};
	assign s_try  = sr_q + sb_q;
	assign d_sh   = ~cnt_q[3:0];
	assign d_div  = {16'd0, e_norm} << d_sh;
	assign c_xs   = cx_q >>> cnt_q;
	assign c_ys   = cy_q >>> cnt_q;
	assign c_at   = rpc_pkg::atan_at(cnt_q);
	assign v_trunc = p_q[27:12];
	assign v_mag  = clamp_q ? quo_q : v_trunc;
	assign v_out  = e_neg ? 16'(-v_mag) : v_mag;
	assign prod   = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			rpc_pkg::OP_MUL_CDX: begin
				ma = 33'(cos_q);
				mb = dx_q;
			end
			rpc_pkg::OP_MUL_SDY: begin
				ma = 33'(sin_q);
				mb = dy_q;
			end
			rpc_pkg::OP_MUL_SDX: begin
				ma = 33'(sin_q);
				mb = dx_q;
			end
			rpc_pkg::OP_MUL_CDY: begin
				ma = 33'(cos_q);
				mb = dy_q;
			end
			rpc_pkg::OP_MUL_EX2: begin
				ma = 33'(ex_q);
				mb = 33'(ex_q);
			end
			rpc_pkg::OP_MUL_EY2: begin
				ma = 33'(ey_q);
				mb = 33'(ey_q);
			end
			rpc_pkg::OP_MUL_TOL: begin
				ma = {2'b00, tol_q};
				mb = {2'b00, tol_q};
			end
			rpc_pkg::OP_MUL_GE: begin
				ma = {17'd0, gain_q};
				mb = {1'b0, e_norm};
			end
			rpc_pkg::OP_MUL_V: begin
				ma = clamp_q ? {18'd0, ms_q} : {17'd0, gain_q};
				mb = {1'b0, e_abs};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		tx = '0;
		ty = '0;
		case (cmd.edge_idx)
			rpc_pkg::EDGE_PX: tx = 40'(side_x_q);
			rpc_pkg::EDGE_PY: ty = 40'(side_y_q);
			rpc_pkg::EDGE_NX: tx = -40'(side_x_q);
			default: ty = -40'(side_y_q);
		endcase
	end

	assign rsum = (cmd.op == rpc_pkg::OP_MUL_SDX) ? (acc_q - p_q + 66'sd8192)
		: (acc_q + p_q + 66'sd8192);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 16'd307;
			ms_q     <= 15'd1024;
			tol_q    <= 31'd1311;
			side_x_q <= 32'sd32768;
			side_y_q <= 32'sd32768;
		end else if (cfg_we) begin
			case (cfg_idx)
				rpc_pkg::CFG_GAIN:      gain_q   <= cfg_data[15:0];
				rpc_pkg::CFG_MAX_SPEED: ms_q     <= cfg_data[14:0];
				rpc_pkg::CFG_TOLERANCE: tol_q    <= cfg_data[30:0];
				rpc_pkg::CFG_SIDE_X:    side_x_q <= cfg_data;
				rpc_pkg::CFG_SIDE_Y:    side_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			cos_q   <= '0;
			sin_q   <= '0;
		end else if (cmd.op == rpc_pkg::OP_CINIT) begin
			org_x_q <= px_q;
			org_y_q <= py_q;
		end else if (cmd.op == rpc_pkg::OP_CFIN) begin
			cos_q <= flip_q ? -rnd_clamp(cx_q) : rnd_clamp(cx_q);
			sin_q <= flip_q ? -rnd_clamp(cy_q) : rnd_clamp(cy_q);
		end
	end

	always_ff @(posedge clk) begin
		p_q <= prod;
		if (cmd.load_out) begin
			velx_q <= vx_q;
			vely_q <= vy_q;
		end
		case (cmd.op)
			rpc_pkg::OP_LATCH: begin
				px_q <= pos_x;
				py_q <= pos_y;
				hd_q <= heading;
				vx_q <= '0;
				vy_q <= '0;
			end
			rpc_pkg::OP_CINIT: begin
				cx_q   <= rpc_pkg::CORDIC_K;
				cy_q   <= '0;
				cz_q   <= 34'(signed'(a_ang));
				flip_q <= a_neg[15] ^ a_neg[14];
				cnt_q  <= '0;
			end
			rpc_pkg::OP_CSTEP: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - c_ys;
					cy_q <= cy_q + c_xs;
					cz_q <= cz_q - c_at;
				end else begin
					cx_q <= cx_q + c_ys;
					cy_q <= cy_q - c_xs;
					cz_q <= cz_q + c_at;
				end
				cnt_q <= cnt_q + 5'd1;
			end
			rpc_pkg::OP_DIFF: begin
				dx_q <= 33'(px_q) - 33'(org_x_q);
				dy_q <= 33'(py_q) - 33'(org_y_q);
			end
			rpc_pkg::OP_MUL_SDY: acc_q <= p_q;
			rpc_pkg::OP_MUL_SDX: bx_q <= rsum[51:14];
			rpc_pkg::OP_MUL_CDY: acc_q <= p_q;
			rpc_pkg::OP_BY: by_q <= rsum[51:14];
			rpc_pkg::OP_ERR: begin
				ex_q <= sat32(tx - 40'(bx_q));
				ey_q <= sat32(ty - 40'(by_q));
			end
			rpc_pkg::OP_MUL_EY2: acc_q <= p_q;
			rpc_pkg::OP_MUL_TOL: acc_q <= acc_q + p_q;
			rpc_pkg::OP_SINIT: begin
				sn_q  <= acc_q[63:0];
				sr_q  <= '0;
				sb_q  <= 64'h4000_0000_0000_0000;
				cnt_q <= '0;
			end
			rpc_pkg::OP_SSTEP: begin
				if (sn_q >= s_try) begin
					sn_q <= sn_q - s_try;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q  <= sb_q >> 2;
				cnt_q <= cnt_q + 5'd1;
			end
			rpc_pkg::OP_CLAMP: clamp_q <= p_q > 66'({ms_q, 12'd0});
			rpc_pkg::OP_VSET: begin
				rem_q <= p_q[47:0];
				quo_q <= '0;
				cnt_q <= '0;
				if (!clamp_q) begin
					if (cmd.lane) begin
						vy_q <= v_out;
					end else begin
						vx_q <= v_out;
					end
				end
			end
			rpc_pkg::OP_DSTEP: begin
				if (rem_q >= d_div) begin
					rem_q       <= rem_q - d_div;
					quo_q[d_sh] <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
			rpc_pkg::OP_DFIN: begin
				if (cmd.lane) begin
					vy_q <= v_out;
				end else begin
					vx_q <= v_out;
				end
			end
			default: ;
		endcase
	end

	assign stat.c_last = cnt_q == C_LAST;
	assign stat.s_last = cnt_q == 5'd31;
	assign stat.d_last = cnt_q == 5'd15;
	assign stat.near   = acc_q[63:0] < p_q[63:0];
	assign stat.clamp  = clamp_q;
	assign vel_x = velx_q;
	assign vel_y = vely_q;

endmodule
`default_nettype wire

@@ design/rpc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle path controller sequencer
// Tick-level mode and edge tracking and the per-tick command sequence.
// ----------------------------------------------------------------------------
module rpc_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           start_req,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          phase,
	output logic [1:0]                          edge_res,
	output logic [rpc_pkg::LAP_W-1:0]           lap,
	output logic                                edge_done,
	output rpc_pkg::dp_cmd_t                    cmd,
	input  wire rpc_pkg::dp_stat_t              stat
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CINIT = 5'd1;
	localparam logic [4:0] S_CSTEP = 5'd2;
	localparam logic [4:0] S_CFIN  = 5'd3;
	localparam logic [4:0] S_DIFF  = 5'd4;
	localparam logic [4:0] S_MCDX  = 5'd5;
	localparam logic [4:0] S_MSDY  = 5'd6;
	localparam logic [4:0] S_MSDX  = 5'd7;
	localparam logic [4:0] S_MCDY  = 5'd8;
	localparam logic [4:0] S_BY    = 5'd9;
	localparam logic [4:0] S_ERR   = 5'd10;
	localparam logic [4:0] S_MEX2  = 5'd11;
	localparam logic [4:0] S_MEY2  = 5'd12;
	localparam logic [4:0] S_MTOL  = 5'd13;
	localparam logic [4:0] S_SINIT = 5'd14;
	localparam logic [4:0] S_SSTEP = 5'd15;
	localparam logic [4:0] S_MGE   = 5'd16;
	localparam logic [4:0] S_CLAMP = 5'd17;
	localparam logic [4:0] S_MV    = 5'd18;
	localparam logic [4:0] S_VSET  = 5'd19;
	localparam logic [4:0] S_DSTEP = 5'd20;
	localparam logic [4:0] S_DFIN  = 5'd21;
	localparam logic [4:0] S_OUT   = 5'd22;

	logic [4:0]                  state_q;
	logic [1:0]                  mode_q, edge_q;
	logic [rpc_pkg::LAP_W-1:0]   laps_q, dwell_q, lap_limit_q, dwell_ticks_q;
	logic                        fresh_q, done_q, lane_q, out_valid_q;
	logic [1:0]                  phase_q, edge_o_q;
	logic [rpc_pkg::LAP_W-1:0]   lap_o_q;
	logic                        done_o_q;

	logic                        in_acc, out_load;
	logic [1:0]                  s_mode, s_edge;
	logic [rpc_pkg::LAP_W-1:0]   s_laps, s_dwell;
	logic                        s_fresh, s_run;
	rpc_pkg::adv_t               adv_a, adv_b;

	assign in_stall = state_q != S_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign adv_b    = rpc_pkg::adv_edge(edge_q, laps_q, lap_limit_q);

	always_comb begin
		s_mode  = mode_q;
		s_edge  = edge_q;
		s_laps  = laps_q;
		s_dwell = dwell_q;
		s_fresh = fresh_q;
		adv_a   = '0;
		if (start_req) begin
			s_laps  = '0;
			s_edge  = rpc_pkg::EDGE_PX;
			s_dwell = '0;
			s_fresh = 1'b1;
			s_mode  = (lap_limit_q == '0) ? rpc_pkg::MODE_DONE : rpc_pkg::MODE_DRIVE;
		end
		s_run = (s_mode == rpc_pkg::MODE_DRIVE);
		if (s_mode == rpc_pkg::MODE_DWELL) begin
			if (s_dwell != '0) begin
				s_dwell = s_dwell - 16'd1;
			end
			if (s_dwell == '0) begin
				adv_a  = rpc_pkg::adv_edge(s_edge, s_laps, lap_limit_q);
				s_edge = adv_a.edge_idx;
				s_laps = adv_a.laps;
				if (adv_a.fin) begin
					s_mode = rpc_pkg::MODE_DONE;
				end else begin
					s_mode  = rpc_pkg::MODE_DRIVE;
					s_fresh = 1'b1;
				end
			end
		end
	end

	always_comb begin
		cmd.lane     = lane_q;
		cmd.edge_idx = edge_q;
		cmd.load_out = out_load;
		case (state_q)
			S_IDLE:  cmd.op = in_acc ? rpc_pkg::OP_LATCH : rpc_pkg::OP_NONE;
			S_CINIT: cmd.op = rpc_pkg::OP_CINIT;
			S_CSTEP: cmd.op = rpc_pkg::OP_CSTEP;
			S_CFIN:  cmd.op = rpc_pkg::OP_CFIN;
			S_DIFF:  cmd.op = rpc_pkg::OP_DIFF;
			S_MCDX:  cmd.op = rpc_pkg::OP_MUL_CDX;
			S_MSDY:  cmd.op = rpc_pkg::OP_MUL_SDY;
			S_MSDX:  cmd.op = rpc_pkg::OP_MUL_SDX;
			S_MCDY:  cmd.op = rpc_pkg::OP_MUL_CDY;
			S_BY:    cmd.op = rpc_pkg::OP_BY;
			S_ERR:   cmd.op = rpc_pkg::OP_ERR;
			S_MEX2:  cmd.op = rpc_pkg::OP_MUL_EX2;
			S_MEY2:  cmd.op = rpc_pkg::OP_MUL_EY2;
			S_MTOL:  cmd.op = rpc_pkg::OP_MUL_TOL;
			S_SINIT: cmd.op = rpc_pkg::OP_SINIT;
			S_SSTEP: cmd.op = rpc_pkg::OP_SSTEP;
			S_MGE:   cmd.op = rpc_pkg::OP_MUL_GE;
			S_CLAMP: cmd.op = rpc_pkg::OP_CLAMP;
			S_MV:    cmd.op = rpc_pkg::OP_MUL_V;
			S_VSET:  cmd.op = rpc_pkg::OP_VSET;
			S_DSTEP: cmd.op = rpc_pkg::OP_DSTEP;
			S_DFIN:  cmd.op = rpc_pkg::OP_DFIN;
			default: cmd.op = rpc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_limit_q   <= 16'd100;
			dwell_ticks_q <= 16'd25;
		end else if (cfg_we) begin
			case (cfg_idx)
				rpc_pkg::CFG_LAP_LIMIT: lap_limit_q   <= cfg_data[15:0];
				rpc_pkg::CFG_DWELL:     dwell_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= rpc_pkg::MODE_IDLE;
			edge_q      <= rpc_pkg::EDGE_PX;
			laps_q      <= '0;
			dwell_q     <= '0;
			fresh_q     <= 1'b1;
			done_q      <= 1'b0;
			lane_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q  <= s_mode;
						edge_q  <= s_edge;
						laps_q  <= s_laps;
						dwell_q <= s_dwell;
						fresh_q <= s_fresh;
						done_q  <= 1'b0;
						lane_q  <= 1'b0;
						if (s_run) begin
							state_q <= s_fresh ? S_CINIT : S_DIFF;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_CINIT: state_q <= S_CSTEP;
				S_CSTEP: begin
					if (stat.c_last) begin
						state_q <= S_CFIN;
					end
				end
				S_CFIN: begin
					fresh_q <= 1'b0;
					state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_MCDX;
				S_MCDX: state_q <= S_MSDY;
				S_MSDY: state_q <= S_MSDX;
				S_MSDX: state_q <= S_MCDY;
				S_MCDY: state_q <= S_BY;
				S_BY:   state_q <= S_ERR;
				S_ERR:  state_q <= S_MEX2;
				S_MEX2: state_q <= S_MEY2;
				S_MEY2: state_q <= S_MTOL;
				S_MTOL: state_q <= S_SINIT;
				S_SINIT: begin
					if (stat.near) begin
						done_q <= 1'b1;
						if (dwell_ticks_q == '0) begin
							edge_q <= adv_b.edge_idx;
							laps_q <= adv_b.laps;
							if (adv_b.fin) begin
								mode_q <= rpc_pkg::MODE_DONE;
							end else begin
								mode_q  <= rpc_pkg::MODE_DRIVE;
								fresh_q <= 1'b1;
							end
						end else begin
							mode_q  <= rpc_pkg::MODE_DWELL;
							dwell_q <= dwell_ticks_q;
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_SSTEP;
					end
				end
				S_SSTEP: begin
					if (stat.s_last) begin
						state_q <= S_MGE;
					end
				end
				S_MGE:   state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_MV;
				S_MV:    state_q <= S_VSET;
				S_VSET: begin
					if (stat.clamp) begin
						state_q <= S_DSTEP;
					end else if (!lane_q) begin
						lane_q  <= 1'b1;
						state_q <= S_MV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DSTEP: begin
					if (stat.d_last) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					if (!lane_q) begin
						lane_q  <= 1'b1;
						state_q <= S_MV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			phase_q  <= mode_q;
			edge_o_q <= edge_q;
			lap_o_q  <= laps_q;
			done_o_q <= done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign phase     = phase_q;
	assign edge_res  = edge_o_q;
	assign lap       = lap_o_q;
	assign edge_done = done_o_q;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle path controller testbench
// Drives control ticks against a cycle-free copy of the controller behavior
// and checks every velocity command, phase, edge, lap count and edge flag.
// ----------------------------------------------------------------------------
module tb;
	import rpc_pkg::*;

	typedef struct packed {
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic [1:0]              ph;
		logic [1:0]              side;
		logic [LAP_W-1:0]        lp;
		logic                    dn;
	} cmd_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic start_req;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [ANG_W-1:0] heading;
	logic out_valid;
	logic out_stall;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic [1:0] phase;
	logic [1:0] edge_res;
	logic [LAP_W-1:0] lap;
	logic edge_done;

	rectangle_path_position_controller i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .start_req(start_req), .pos_x(pos_x),
		.pos_y(pos_y), .heading(heading), .out_valid(out_valid), .out_stall(out_stall),
		.vel_x(vel_x), .vel_y(vel_y), .phase(phase), .edge_res(edge_res), .lap(lap),
		.edge_done(edge_done)
	);

	// Controller copy: registers and state.
	longint unsigned k_gain, k_maxspd, k_tol, k_laplim, k_dwell;
	longint k_side_x, k_side_y;
	logic [1:0] s_mode, s_side;
	logic [15:0] s_laps, s_dwell;
	bit s_fresh;
	longint s_ox, s_oy, s_cos, s_sin;

	cmd_t pending_cmds[$];
	int mismatches;
	bit calm;
	bit hold_req;
	int hold_cnt;
	int stall_left;

	longint atan_q30[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void latch_frame(input logic [15:0] hd);
		logic [31:0] a;
		bit flip;
		longint x, y, z, xs, ys;
		a = {16'(16'h0 - hd), 16'h0};
		flip = 0;
		if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
			a = a - 32'h8000_0000;
			flip = 1;
		end
		z = longint'($signed(a));
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_q30[i];
			end else begin
				x = x + ys; y = y - xs; z = z + atan_q30[i];
			end
		end
		x = (x + 32768) >>> 16;
		y = (y + 32768) >>> 16;
		if (x > 16384) x = 16384;
		if (x < -16384) x = -16384;
		if (y > 16384) y = 16384;
		if (y < -16384) y = -16384;
		s_cos = flip ? -x : x;
		s_sin = flip ? -y : y;
	endfunction

	function automatic void next_side();
		s_side = s_side + 2'd1;
		if (s_side == EDGE_PX && s_laps != 16'hFFFF) s_laps = s_laps + 16'd1;
		if (s_side == EDGE_PX && s_laps >= k_laplim) begin
			s_mode = MODE_DONE;
		end else begin
			s_mode = MODE_DRIVE;
			s_fresh = 1;
		end
	endfunction

	function automatic longint speed_of(input longint e, input longint unsigned en,
		input bit lim);
		longint unsigned m, v;
		m = (e < 0) ? -e : e;
		v = lim ? (k_maxspd * m) / en : (k_gain * m) >> 12;
		return (e < 0) ? -longint'(v) : longint'(v);
	endfunction

	function automatic void target_of(output longint tx, output longint ty);
		tx = 0;
		ty = 0;
		case (s_side)
			EDGE_PX: tx = k_side_x;
			EDGE_PY: ty = k_side_y;
			EDGE_NX: tx = -k_side_x;
			default: ty = -k_side_y;
		endcase
	endfunction

	function automatic cmd_t plan_tick(input bit st, input logic [31:0] px_in,
		input logic [31:0] py_in, input logic [15:0] hd);
		longint px, py, dx, dy, bx, by, tx, ty, ex, ey, vx, vy;
		longint unsigned n2, en;
		bit lim, dn;
		cmd_t r;
		px = longint'($signed(px_in));
		py = longint'($signed(py_in));
		vx = 0;
		vy = 0;
		dn = 0;
		if (st) begin
			s_laps = 0; s_side = EDGE_PX; s_dwell = 0; s_fresh = 1;
			s_mode = (k_laplim == 0) ? MODE_DONE : MODE_DRIVE;
		end
		if (s_mode == MODE_DRIVE) begin
			if (s_fresh) begin
				s_ox = px;
				s_oy = py;
				latch_frame(hd);
				s_fresh = 0;
			end
			dx = px - s_ox;
			dy = py - s_oy;
			bx = (s_cos * dx - s_sin * dy + 8192) >>> 14;
			by = (s_sin * dx + s_cos * dy + 8192) >>> 14;
			target_of(tx, ty);
			ex = sat32(tx - bx);
			ey = sat32(ty - by);
			n2 = longint'(ex * ex) + longint'(ey * ey);
			if (n2 < k_tol * k_tol) begin
				dn = 1;
				if (k_dwell == 0) begin
					next_side();
				end else begin
					s_mode = MODE_DWELL;
					s_dwell = k_dwell[15:0];
				end
			end else begin
				en = root_floor(n2);
				lim = k_gain * en > k_maxspd * 4096;
				vx = speed_of(ex, en, lim);
				vy = speed_of(ey, en, lim);
			end
		end else if (s_mode == MODE_DWELL) begin
			if (s_dwell != 0) s_dwell = s_dwell - 16'd1;
			if (s_dwell == 0) next_side();
		end
		r.vx = vx[15:0];
		r.vy = vy[15:0];
		r.ph = s_mode;
		r.side = s_side;
		r.lp = s_laps;
		r.dn = dn;
		return r;
	endfunction

	// Position that lands close to the current edge target in the latched frame.
	function automatic void on_target(output logic [31:0] px, output logic [31:0] py);
		longint tx, ty, dx, dy;
		target_of(tx, ty);
		dx = (s_cos * tx + s_sin * ty) >>> 14;
		dy = (s_cos * ty - s_sin * tx) >>> 14;
		px = 32'(s_ox + dx + $signed($urandom_range(0, 400)) - 200);
		py = 32'(s_oy + dy + $signed($urandom_range(0, 400)) - 200);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_GAIN: k_gain = val[15:0];
			CFG_MAX_SPEED: k_maxspd = val[14:0];
			CFG_TOLERANCE: k_tol = val[30:0];
			CFG_SIDE_X: k_side_x = longint'($signed(val));
			CFG_SIDE_Y: k_side_y = longint'($signed(val));
			CFG_LAP_LIMIT: k_laplim = val[15:0];
			CFG_DWELL: k_dwell = val[15:0];
			default: ;
		endcase
	endtask

	task automatic cfg_close();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick(input bit st, input logic [31:0] px, input logic [31:0] py,
		input logic [15:0] hd);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= st;
		pos_x <= px;
		pos_y <= py;
		heading <= hd;
		do @(posedge clk); while (in_stall);
		pending_cmds.push_back(plan_tick(st, px, py, hd));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// One tick with mostly well-formed motion: arrivals, starts and wild poses.
	task automatic random_tick();
		logic [31:0] px, py;
		bit st;
		int pick;
		pick = $urandom_range(0, 99);
		st = (pick < 4) || ((s_mode == MODE_IDLE || s_mode == MODE_DONE) && pick < 40);
		if (s_mode == MODE_DRIVE && !s_fresh && pick >= 45) begin
			on_target(px, py);
		end else if (pick < 90) begin
			px = 32'($signed($urandom_range(0, 2000000)) - 1000000);
			py = 32'($signed($urandom_range(0, 2000000)) - 1000000);
		end else begin
			px = $urandom;
			py = $urandom;
		end
		send_tick(st, px, py, 16'($urandom));
	endtask

	task automatic random_config();
		cfg_write(CFG_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1200));
		cfg_write(CFG_MAX_SPEED, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000));
		cfg_write(CFG_TOLERANCE, $urandom_range(0, 7) == 0 ? $urandom
			: $urandom_range(300, 20000));
		cfg_write(CFG_SIDE_X, $urandom_range(0, 7) == 0 ? $urandom
			: 32'($signed($urandom_range(0, 2000000)) - 1000000));
		cfg_write(CFG_SIDE_Y, $urandom_range(0, 7) == 0 ? $urandom
			: 32'($signed($urandom_range(0, 2000000)) - 1000000));
		cfg_write(CFG_LAP_LIMIT, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3));
		cfg_write(CFG_DWELL, $urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
			: $urandom_range(0, 3));
		cfg_close();
	endtask

	task automatic test_idle_extremes();
		send_tick(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
		send_tick(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_tick(1, 32'h0000_0000, 32'h0000_0000, 16'h4000);
		send_tick(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
		send_tick(1, 32'h8000_0000, 32'h8000_0000, 16'hC000);
		send_tick(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h2000);
		settle();
	endtask

	task automatic test_lap_zero();
		cfg_write(CFG_LAP_LIMIT, 32'd0);
		cfg_close();
		send_tick(1, 32'd100, 32'd100, 16'h1234);
		send_tick(0, 32'd100, 32'd100, 16'h1234);
		settle();
	endtask

	task automatic test_full_lap();
		logic [31:0] px, py;
		cfg_write(CFG_LAP_LIMIT, 32'd1);
		cfg_write(CFG_DWELL, 32'd0);
		cfg_write(CFG_TOLERANCE, 32'd3000);
		cfg_close();
		send_tick(1, 32'd5000, 32'hFFFF_0000, 16'h3000);
		for (int i = 0; i < 8; i++) begin
			on_target(px, py);
			send_tick(0, px, py, 16'($urandom));
		end
		settle();
		cfg_write(CFG_DWELL, 32'd2);
		cfg_close();
		send_tick(1, 32'd0, 32'd0, 16'h0000);
		for (int i = 0; i < 6; i++) begin
			on_target(px, py);
			send_tick(0, px, py, 16'h0000);
		end
		settle();
	endtask

	task automatic test_config_extremes();
		cfg_write(CFG_GAIN, 32'hFFFF);
		cfg_write(CFG_MAX_SPEED, 32'h7FFF);
		cfg_write(CFG_TOLERANCE, 32'd0);
		cfg_write(CFG_SIDE_X, 32'h7FFF_FFFF);
		cfg_write(CFG_SIDE_Y, 32'h8000_0000);
		cfg_write(CFG_LAP_LIMIT, 32'hFFFF);
		cfg_write(CFG_DWELL, 32'hFFFF);
		cfg_close();
		send_tick(1, 32'h8000_0000, 32'h7FFF_FFFF, 16'hA000);
		send_tick(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
		settle();
		cfg_write(CFG_GAIN, 32'd0);
		cfg_write(CFG_MAX_SPEED, 32'd0);
		cfg_write(CFG_TOLERANCE, 32'h7FFF_FFFF);
		cfg_close();
		send_tick(0, 32'd0, 32'd0, 16'h0);
		send_tick(0, 32'd0, 32'd0, 16'h0);
		settle();
		cfg_write(CFG_TOLERANCE, 32'd1);
		cfg_write(CFG_GAIN, 32'hFFFF);
		cfg_write(CFG_MAX_SPEED, 32'd1);
		cfg_close();
		send_tick(1, 32'd0, 32'd0, 16'h8000);
		send_tick(0, 32'h0001_0000, 32'hFFFF_0000, 16'h0);
		settle();
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 10; p++) begin
			random_config();
			send_tick(1, $urandom, $urandom, 16'($urandom));
			for (int i = 0; i < 50; i++) random_tick();
			settle();
		end
	endtask

	task automatic test_backpressure();
		hold_req <= 1'b1;
		for (int i = 0; i < 20; i++) random_tick();
		settle();
	endtask

	task automatic test_calm_run();
		calm = 1;
		random_config();
		send_tick(1, 32'd0, 32'd0, 16'($urandom));
		for (int i = 0; i < 60; i++) random_tick();
		settle();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req <= 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cmd_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{vel_x, vel_y, phase, edge_res, lap, edge_done};
			if (pending_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %p", got);
			end else begin
				want = pending_cmds.pop_front();
				if (got.vx !== want.vx || got.vy !== want.vy || got.ph !== want.ph ||
					got.side !== want.side || got.lp !== want.lp || got.dn !== want.dn) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		start_req = 1'b0;
		pos_x = '0;
		pos_y = '0;
		heading = '0;
		out_stall = 1'b0;
		calm = 0;
		hold_req = 1'b0;
		hold_cnt = 0;
		stall_left = 0;
		mismatches = 0;
		k_gain = 307; k_maxspd = 1024; k_tol = 1311; k_side_x = 32768; k_side_y = 32768;
		k_laplim = 100; k_dwell = 25;
		s_mode = MODE_IDLE; s_side = EDGE_PX; s_laps = 0; s_dwell = 0; s_fresh = 1;
		s_ox = 0; s_oy = 0; s_cos = 0; s_sin = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		test_idle_extremes();
		test_lap_zero();
		test_full_lap();
		test_config_extremes();
		test_random_settings();
		test_backpressure();
		test_calm_run();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_cmds.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
